// ===== rtl/modinv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_pkg
// Types, microcode encoding and control store of the modular inverse unit.
// ----------------------------------------------------------------------------
package modinv_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ModW   = 63;
  localparam int unsigned PcW    = 3;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_ALIGN   = 3'd1,
    OP_DIVSTEP = 3'd2,
    OP_FIXRED  = 3'd3,
    OP_SWAP    = 3'd4,
    OP_FINISH  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE  = 3'd0,
    COND_ALIGN = 3'd1,
    COND_DIV   = 3'd2,
    COND_REMNZ = 3'd3,
    COND_END   = 3'd4
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic align_more;
    logic div_more;
    logic rem_nz;
  } dp_status_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic run;
    op_e  op;
  } dp_ctrl_t;

  localparam logic [PcW-1:0] PcRedAlign = 3'd0;
  localparam logic [PcW-1:0] PcRedDiv   = 3'd1;
  localparam logic [PcW-1:0] PcFixRed   = 3'd2;
  localparam logic [PcW-1:0] PcEuAlign  = 3'd3;
  localparam logic [PcW-1:0] PcEuDiv    = 3'd4;
  localparam logic [PcW-1:0] PcSwap     = 3'd5;
  localparam logic [PcW-1:0] PcFinish   = 3'd6;

  // Program: reduce value mod m, then extended Euclid until the remainder is zero.
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_END, target: PcRedAlign};
    case (pc)
      PcRedAlign: w = '{op: OP_ALIGN,   cond: COND_ALIGN, target: PcRedAlign};
      PcRedDiv:   w = '{op: OP_DIVSTEP, cond: COND_DIV,   target: PcRedDiv};
      PcFixRed:   w = '{op: OP_FIXRED,  cond: COND_NONE,  target: PcEuAlign};
      PcEuAlign:  w = '{op: OP_ALIGN,   cond: COND_ALIGN, target: PcEuAlign};
      PcEuDiv:    w = '{op: OP_DIVSTEP, cond: COND_DIV,   target: PcEuDiv};
      PcSwap:     w = '{op: OP_SWAP,    cond: COND_REMNZ, target: PcEuAlign};
      PcFinish:   w = '{op: OP_FINISH,  cond: COND_END,   target: PcRedAlign};
      default:    w = '{op: OP_NOP,     cond: COND_END,   target: PcRedAlign};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/modinv_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module modinv_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    launch_i,
  input  modinv_pkg::dp_status_t  status_i,
  output modinv_pkg::dp_ctrl_t    ctrl_o,
  output logic                    busy_o
);
  import modinv_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  logic           run_q, run_d;
  uword_t         uw;
  logic           take;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    take = 1'b0;
    case (uw.cond)
      COND_NONE:  take = 1'b0;
      COND_ALIGN: take = status_i.align_more;
      COND_DIV:   take = status_i.div_more;
      COND_REMNZ: take = status_i.rem_nz;
      COND_END:   take = 1'b1;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d  = pc_q;
    run_d = run_q;
    if (run_q) begin
      pc_d = take ? uw.target : pc_q + 1'b1;
      if (uw.cond == COND_END) begin
        run_d = 1'b0;
      end
    end else if (launch_i) begin
      pc_d  = PcRedAlign;
      run_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PcRedAlign;
      run_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      run_q <= run_d;
    end
  end

  assign ctrl_o.run = run_q;
  assign ctrl_o.op  = run_q ? uw.op : OP_NOP;
  assign busy_o     = run_q;

endmodule

// ===== rtl/modular_inverse_ext_euclid_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit
// Modular inverse of a signed 64-bit value by the extended Euclidean method.
// ----------------------------------------------------------------------------
// Pulse start while busy is low; value_i and modulus_i are sampled on that
// edge. The result appears on inverse_o/exists_o for one cycle with valid_o
// high and must be taken then: there is no back-pressure. One shift-subtract
// divider, driven by a small microprogram, does all the work one quotient bit
// per cycle: first value mod modulus, then each Euclid quotient, with the
// divisor aligned one bit per cycle before the subtract pass. Busy stays high
// until the finish step of the microprogram has run; the result beat comes in
// the first cycle with busy low.
// Modulus zero returns inverse 0 with exists clear.
module modular_inverse_ext_euclid_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [modinv_pkg::ValueW-1:0] value_i,
  input  logic [modinv_pkg::ModW-1:0]   modulus_i,
  output logic                          busy,
  output logic                          valid_o,
  output logic [modinv_pkg::ModW-1:0]   inverse_o,
  output logic                          exists_o
);
  import modinv_pkg::*;

  logic              launch;
  dp_ctrl_t          ctrl;
  dp_status_t        status;

  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] d_q, d_d;
  logic [ModW-1:0]   b_q, b_d;
  logic [ModW-1:0]   m_q, m_d;
  logic [ValueW-1:0] x0_q, x0_d;
  logic [ValueW-1:0] x1_q, x1_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;

  logic              valid_q, valid_d;
  logic [ModW-1:0]   inv_q, inv_d;
  logic              ex_q, ex_d;

  logic [ValueW-1:0] mag;
  logic              ge;
  logic [ValueW-1:0] x0_norm;

  assign launch = start && !busy;
  assign mag    = value_i[ValueW-1] ? (~value_i) + 1'b1 : value_i;
  assign ge     = rem_q >= d_q;

  // divisor may still double without passing the dividend
  assign status.align_more = !d_q[ValueW-1] && (d_q != '0)
                             && ({d_q[ValueW-2:0], 1'b0} <= rem_q);
  assign status.div_more   = d_q != {1'b0, b_q};
  assign status.rem_nz     = rem_q != '0;

  assign x0_norm = x0_q[ValueW-1] ? x0_q + {1'b0, m_q} : x0_q;

  always_comb begin
    rem_d   = rem_q;
    d_d     = d_q;
    b_d     = b_q;
    m_d     = m_q;
    x0_d    = x0_q;
    x1_d    = x1_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    valid_d = 1'b0;
    inv_d   = inv_q;
    ex_d    = ex_q;
    if (launch) begin
      rem_d  = mag;
      d_d    = {1'b0, modulus_i};
      b_d    = modulus_i;
      m_d    = modulus_i;
      x0_d   = ValueW'(1);
      x1_d   = '0;
      acc_d  = '0;
      neg_d  = value_i[ValueW-1];
      zero_d = modulus_i == '0;
    end else begin
      case (ctrl.op)
        OP_NOP: ;
        OP_ALIGN: begin
          if (status.align_more) begin
            d_d = {d_q[ValueW-2:0], 1'b0};
          end
        end
        OP_DIVSTEP: begin
          // quotient bits arrive MSB first: acc accumulates q * x1
          rem_d = ge ? rem_q - d_q : rem_q;
          acc_d = {acc_q[ValueW-2:0], 1'b0} + (ge ? x1_q : '0);
          d_d   = d_q >> 1;
        end
        OP_FIXRED: begin
          if (neg_q && (rem_q != '0)) begin
            rem_d = {1'b0, m_q} - rem_q;
          end
          d_d = {1'b0, b_q};
        end
        OP_SWAP: begin
          rem_d = {1'b0, b_q};
          b_d   = rem_q[ModW-1:0];
          d_d   = {1'b0, rem_q[ModW-1:0]};
          x0_d  = x1_q;
          x1_d  = x0_q - acc_q;
          acc_d = '0;
        end
        OP_FINISH: begin
          valid_d = 1'b1;
          ex_d    = (rem_q == ValueW'(1)) && !zero_q;
          inv_d   = ex_d ? x0_norm[ModW-1:0] : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    d_q    <= d_d;
    b_q    <= b_d;
    m_q    <= m_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    inv_q  <= inv_d;
    ex_q   <= ex_d;
  end

  modinv_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (launch),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  assign valid_o   = valid_q;
  assign inverse_o = inv_q;
  assign exists_o  = ex_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the extended Euclidean modular inverse unit. It
// starts with directed operand pairs at the edges and then runs random phases.
// The random pairs are shaped toward deep Euclid runs, shared factors,
// multiples of the modulus and extreme values, with random or no input gaps.
// A scoreboard class predicts each result and checks each output beat.
// ----------------------------------------------------------------------------
module testbench;

  import modinv_pkg::*;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [ModW-1:0]   modulus;
    logic [ModW-1:0]   inverse;
    logic              exists;
  } inv_result_t;

  class modinv_scoreboard;
    inv_result_t expected_q[$];
    int          errors = 0;

    // extended Euclid with wrapping 64-bit coefficients
    function inv_result_t compute_inverse(logic [ValueW-1:0] v, logic [ModW-1:0] m);
      inv_result_t res;
      logic [63:0] mm, mag, r, a, b, x0, x1, q, nb, nx;
      res.value   = v;
      res.modulus = m;
      res.inverse = '0;
      res.exists  = 1'b0;
      mm = {1'b0, m};
      if (mm == 64'd0) return res;
      if (v[63]) begin
        mag = ~v + 64'd1;
        r   = mag % mm;
        a   = (r == 64'd0) ? 64'd0 : mm - r;
      end else begin
        a = v % mm;
      end
      b  = mm;
      x0 = 64'd1;
      x1 = 64'd0;
      while (b != 64'd0) begin
        q  = a / b;
        nb = a - q * b;
        nx = x0 - q * x1;
        a  = b;
        b  = nb;
        x0 = x1;
        x1 = nx;
      end
      if (a != 64'd1) return res;
      if (x0[63]) x0 = x0 + mm;
      res.inverse = x0[ModW-1:0];
      res.exists  = 1'b1;
      return res;
    endfunction

    function void note_operands(logic [ValueW-1:0] v, logic [ModW-1:0] m);
      expected_q.insert(expected_q.size(), compute_inverse(v, m));
    endfunction

    function void check_result(logic [ModW-1:0] inv, logic ex);
      inv_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: inverse %0d exists %0b", $time, inv, ex);
        return;
      end
      exp_r = expected_q.pop_front();
      if (inv !== exp_r.inverse) begin
        errors++;
        $display("%0t: inverse mismatch (value %0h modulus %0d): expected %0d actual %0d",
                 $time, exp_r.value, exp_r.modulus, exp_r.inverse, inv);
      end
      if (ex !== exp_r.exists) begin
        errors++;
        $display("%0t: exists mismatch (value %0h modulus %0d): expected %0b actual %0b",
                 $time, exp_r.value, exp_r.modulus, exp_r.exists, ex);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic [ValueW-1:0] value_i;
  logic [ModW-1:0]   modulus_i;
  logic              busy;
  logic              valid_o;
  logic [ModW-1:0]   inverse_o;
  logic              exists_o;

  modinv_scoreboard sb;
  bit               no_idle;

  localparam logic [63:0] MinValue = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxValue = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] MaxMod   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] Mersenne61 = 63'h1FFF_FFFF_FFFF_FFFF;

  modular_inverse_ext_euclid_unit DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .value_i   (value_i),
    .modulus_i (modulus_i),
    .busy      (busy),
    .valid_o   (valid_o),
    .inverse_o (inverse_o),
    .exists_o  (exists_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(inverse_o, exists_o);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random modulus of up to nbits bits, never zero
  function automatic logic [62:0] rand_modulus(int nbits);
    logic [63:0] w;
    logic [62:0] r;
    w = rand64();
    r = w[62:0];
    if (nbits < 63) r = r & ((63'd1 << nbits) - 63'd1);
    if (r == 63'd0) r = 63'd1;
    return r;
  endfunction

  function automatic logic [63:0] fib(int n);
    logic [63:0] f0, f1, t;
    f0 = 64'd0;
    f1 = 64'd1;
    for (int i = 0; i < n; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  task automatic send_item(input logic [63:0] v, input logic [62:0] m);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    value_i   <= v;
    modulus_i <= m;
    do @(posedge clk_i); while (busy);
    sb.note_operands(v, m);
    @(negedge clk_i);
  endtask

  // hold the sender off until every beat in flight has come back
  task automatic wait_results_done();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    logic [63:0] v, k;
    logic [62:0] m, g;
    int          idx;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        m = rand_modulus(63);
        v = rand64();
      end
      3: begin
        m = rand_modulus($urandom_range(1, 63));
        v = rand64();
      end
      4: begin
        m = 63'($urandom_range(1, 1000));
        v = rand64();
      end
      5: begin
        // exact multiple of the modulus, either sign
        m = rand_modulus($urandom_range(1, 31));
        k = 64'($urandom_range(0, 32'h7FFF_FFFF));
        v = k * {1'b0, m};
        if ($urandom_range(0, 1)) v = ~v + 64'd1;
      end
      6: begin
        // common factor above one
        g = 63'($urandom_range(2, 1000));
        m = g * 63'($urandom_range(1, 1 << 20));
        v = {1'b0, g} * 64'($urandom_range(0, 1 << 30));
        if ($urandom_range(0, 1)) v = ~v + 64'd1;
      end
      7: begin
        // consecutive Fibonacci numbers give the longest Euclid runs
        idx = $urandom_range(2, 91);
        m = 63'(fib(idx + 1));
        v = fib(idx);
        if ($urandom_range(0, 1)) v = ~v + 64'd1;
      end
      8: begin
        m = rand_modulus($urandom_range(1, 63));
        case ($urandom_range(0, 8))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = '1;
          3: v = MinValue;
          4: v = MaxValue;
          5: v = {1'b0, m} - 64'd1;
          6: v = {1'b0, m};
          7: v = ~{1'b0, m} + 64'd1;
          default: v = {1'b0, m} + 64'd1;
        endcase
      end
      default: begin
        m = $urandom_range(0, 1) ? MaxMod : Mersenne61;
        v = rand64();
      end
    endcase
    send_item(v, m);
  endtask

  initial begin
    sb        = new();
    rst_ni    = 1'b0;
    start     = 1'b0;
    value_i   = '0;
    modulus_i = 63'd1;
    no_idle   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // modulus one always has inverse zero
    send_item(64'd0, 63'd1);
    send_item(MinValue, 63'd1);
    send_item(MaxValue, 63'd1);
    send_item('1, 63'd1);
    send_item(64'd3, 63'd7);
    send_item(~64'd3 + 64'd1, 63'd7);
    send_item(64'd0, 63'd7);
    send_item(64'd14, 63'd7);
    send_item(~64'd14 + 64'd1, 63'd7);
    send_item(64'd6, 63'd9);
    send_item(MinValue, MaxMod);
    send_item(MaxValue, MaxMod);
    send_item(MaxValue - 64'd1, MaxMod);
    send_item('1, MaxMod);
    send_item(64'd1, MaxMod);
    send_item(MinValue, Mersenne61);
    send_item(MinValue, 63'd2);
    send_item(MaxValue, 63'd2);
    send_item(64'd2, 63'h4000_0000_0000_0000);
    send_item(fib(91), 63'(fib(92)));
    send_item(~fib(90) + 64'd1, 63'(fib(91)));
    send_item(64'd12345678901234567, 63'd1000000007);
    wait_results_done();

    for (int phase = 0; phase < 5; phase++) begin
      no_idle = (phase % 2) == 1;
      for (int n = 0; n < 190; n++) send_random_item();
      wait_results_done();
    end
    no_idle = 1'b0;

    // latency allowance for a late stray beat
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
